// ===== sv/deq_pkg.sv =====
// Shared types, constants and index helpers for the double-ended queue core.
// No dependencies; imported by double_ended_queue_core.
package deq_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = 7;
	localparam int CMD_W  = 3;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int IN_W   = ((CMD_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_W  = ((VAL_W + CNT_W + 7) / 8) * 8;
	localparam int OUT_PAD = OUT_W - VAL_W - CNT_W;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WALK       = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		DQ_IDLE,
		DQ_READ,
		DQ_EMIT
	} dq_state_t;

	// Ring position base + off, where off stays below DEPTH.
	function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return IDX_W'(sum);
	endfunction

	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] base);
		return (base == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(base + IDX_W'(1));
	endfunction

	function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
		return (base == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(base - IDX_W'(1));
	endfunction

endpackage

// ===== sv/double_ended_queue_core.sv =====
// Double-ended queue core: ring store, front index, entry count and sequencer.
// Depends on deq_pkg for widths, command and status codes and ring helpers.

// A push, a full or empty report and an unused command each finish as the input
// is accepted: the input transfer and the result load happen together. A pop
// goes through accept, store read and result load, and a walk starts and then
// reads and emits each held element in turn, because the store has a registered
// read that the sequencer waits on for every element. The store is not cleared
// after reset; only entries written by a push are ever read.
module double_ended_queue_core import deq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // cmd, push_value, zero fill
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // item_value, count, zero fill
	output logic [STAT_W-1:0] m_tuser,   // status
	output logic              m_tlast
);

	logic [VAL_W-1:0] ring_mem [DEPTH];

	dq_state_t        state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] addr_q, addr_d;
	logic             walk_q, walk_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [VAL_W-1:0] rd_data_q;

	logic              out_valid_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [STAT_W-1:0] out_status_q;
	logic              out_last_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [CMD_W-1:0]  cmd;
	logic [VAL_W-1:0]  push_value;
	logic              out_free;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic              rd_en;
	logic              load;
	logic [VAL_W-1:0]  ld_value;
	logic [STAT_W-1:0] ld_status;
	logic              ld_last;

	assign cmd        = s_tdata[CMD_W-1:0];
	assign push_value = s_tdata[CMD_W +: VAL_W];
	assign out_free   = !out_valid_q || m_tready;

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		count_d   = count_q;
		addr_d    = addr_q;
		walk_d    = walk_q;
		idx_d     = idx_q;
		wr_en     = 1'b0;
		wr_addr   = front_q;
		rd_en     = 1'b0;
		load      = 1'b0;
		ld_value  = '0;
		ld_status = STAT_OK;
		ld_last   = 1'b1;
		s_tready  = 1'b0;
		case (state_q)
			DQ_IDLE: begin
				s_tready = out_free;
				if (s_tvalid && out_free) begin
					case (cmd)
						CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
							load = 1'b1;
							if (count_q == CNT_W'(DEPTH)) begin
								ld_status = STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CNT_W'(1);
								if (cmd == CMD_PUSH_FRONT) begin
									front_d = ring_dec(front_q);
									wr_addr = front_d;
								end else begin
									wr_addr = ring_pos(front_q, count_q);
								end
							end
						end
						CMD_POP_FRONT, CMD_POP_BACK: begin
							if (count_q == '0) begin
								load      = 1'b1;
								ld_status = STAT_EMPTY;
							end else begin
								count_d = count_q - CNT_W'(1);
								walk_d  = 1'b0;
								state_d = DQ_READ;
								if (cmd == CMD_POP_FRONT) begin
									addr_d  = front_q;
									front_d = ring_inc(front_q);
								end else begin
									addr_d = ring_pos(front_q, count_q - CNT_W'(1));
								end
							end
						end
						CMD_WALK: begin
							if (count_q == '0) begin
								load      = 1'b1;
								ld_status = STAT_EMPTY;
							end else begin
								walk_d  = 1'b1;
								addr_d  = front_q;
								idx_d   = '0;
								state_d = DQ_READ;
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			DQ_READ: begin
				rd_en   = 1'b1;
				state_d = DQ_EMIT;
			end
			DQ_EMIT: begin
				ld_value = rd_data_q;
				ld_last  = !walk_q || (idx_q + CNT_W'(1) == count_q);
				if (out_free) begin
					load = 1'b1;
					if (ld_last) begin
						state_d = DQ_IDLE;
					end else begin
						idx_d   = idx_q + CNT_W'(1);
						addr_d  = ring_inc(addr_q);
						state_d = DQ_READ;
					end
				end
			end
			default: begin
				state_d = DQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DQ_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			addr_q      <= '0;
			walk_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			addr_q  <= addr_d;
			walk_q  <= walk_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload is loaded with the count as it stands after the command.
	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q  <= ld_value;
			out_status_q <= ld_status;
			out_last_q   <= ld_last;
			out_count_q  <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= push_value;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[addr_q];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, out_count_q, out_value_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== verif/double_ended_queue_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue_core: a directed list and biased random
// command phases drive the slave stream, and a clocked predictor checks every result transfer.
// Depends on deq_pkg and double_ended_queue_core.
module double_ended_queue_core_test;
	import deq_pkg::*;

	localparam int CYCLE_LIMIT = 800_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int LONG_HOLD_AFTER = 150;

	// Command codes that the core treats as no-ops.
	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [CMD_W-1:0] cmd;
	} deq_command_t;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [STAT_W-1:0] status;
		logic              last;
		logic [CNT_W-1:0]  count;
	} deq_outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic [STAT_W-1:0] m_tuser;
	logic              m_tlast;

	deq_command_t pending_commands[$];
	deq_outcome_t expected_outcomes[$];
	deq_outcome_t want;

	// Shadow copy of the deque state.
	logic [VAL_W-1:0] shadow_store [DEPTH];
	logic [IDX_W-1:0] shadow_front = '0;
	logic [CNT_W-1:0] shadow_count = '0;

	int total_items = 0;
	int accepted_count = 0;
	int results_seen = 0;
	int error_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int rx_mode = 0;
	int rx_cycle = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	double_ended_queue_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value);
		deq_command_t c;
		c.cmd = cmd;
		c.value = value;
		pending_commands.push_back(c);
	endtask

	// Percentages of pushes, pops and walks; what is left goes to the spare codes.
	task automatic add_command_phase(input int n, input int push_pct, input int pop_pct,
			input int walk_pct);
		int r;
		logic [CMD_W-1:0] cmd;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < push_pct) begin
				cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
			end else if (r < push_pct + pop_pct) begin
				cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
			end else if (r < push_pct + pop_pct + walk_pct) begin
				cmd = CMD_WALK;
			end else begin
				case ($urandom_range(0, 2))
					0: cmd = CMD_SPARE_A;
					1: cmd = CMD_SPARE_B;
					default: cmd = CMD_SPARE_C;
				endcase
			end
			add_command(cmd, pick_value());
		end
	endtask

	task automatic add_outcome(input logic [VAL_W-1:0] value, input logic [STAT_W-1:0] status,
			input logic last);
		deq_outcome_t o;
		o.value = value;
		o.status = status;
		o.last = last;
		o.count = shadow_count;
		expected_outcomes.push_back(o);
	endtask

	// Updates the shadow deque for one accepted command and queues its results.
	task automatic apply_deque_command(input logic [CMD_W-1:0] cmd,
			input logic [VAL_W-1:0] value);
		logic [VAL_W-1:0] got;
		int n;
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (int'(shadow_count) >= DEPTH) begin
					add_outcome('0, STAT_FULL, 1'b1);
				end else begin
					if (cmd == CMD_PUSH_FRONT) begin
						shadow_front = IDX_W'((int'(shadow_front) + DEPTH - 1) % DEPTH);
						shadow_store[shadow_front] = value;
					end else begin
						shadow_store[(int'(shadow_front) + int'(shadow_count)) % DEPTH] = value;
					end
					shadow_count = shadow_count + 1'b1;
					add_outcome('0, STAT_OK, 1'b1);
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (shadow_count == '0) begin
					add_outcome('0, STAT_EMPTY, 1'b1);
				end else begin
					if (cmd == CMD_POP_FRONT) begin
						got = shadow_store[shadow_front];
						shadow_front = IDX_W'((int'(shadow_front) + 1) % DEPTH);
					end else begin
						got = shadow_store[(int'(shadow_front) + int'(shadow_count) - 1) % DEPTH];
					end
					shadow_count = shadow_count - 1'b1;
					add_outcome(got, STAT_OK, 1'b1);
				end
			end
			CMD_WALK: begin
				n = int'(shadow_count);
				if (n == 0) begin
					add_outcome('0, STAT_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < n; i++) begin
						add_outcome(shadow_store[(int'(shadow_front) + i) % DEPTH], STAT_OK,
							i == n - 1);
					end
				end
			end
			default: begin
				add_outcome('0, STAT_OK, 1'b1);
			end
		endcase
	endtask

	// Stimulus, reset and end of run.
	initial begin
		// Directed part: empty queue, field extremes, wrap of the front index, spare codes.
		add_command(CMD_WALK, 32'h1234_5678);
		add_command(CMD_POP_FRONT, '1);
		add_command(CMD_POP_BACK, 32'h8000_0000);
		add_command(CMD_PUSH_BACK, 32'h7FFF_FFFF);
		add_command(CMD_PUSH_FRONT, 32'h8000_0000);
		add_command(CMD_PUSH_BACK, '0);
		add_command(CMD_PUSH_FRONT, '1);
		add_command(CMD_PUSH_BACK, 32'h5A5A_A5A5);
		add_command(CMD_WALK, '0);
		add_command(CMD_POP_FRONT, 32'h0F0F_0F0F);
		add_command(CMD_POP_BACK, '0);
		add_command(CMD_WALK, '1);
		add_command(CMD_POP_FRONT, '0);
		add_command(CMD_POP_BACK, '0);
		add_command(CMD_POP_BACK, '0);
		add_command(CMD_POP_FRONT, '0);
		add_command(CMD_SPARE_A, '1);
		add_command(CMD_SPARE_B, 32'hA5A5_5A5A);
		add_command(CMD_SPARE_C, 32'h8000_0001);
		add_command(CMD_WALK, '0);

		// Random part: fill to full and beyond, churn, drain past empty, refill, churn.
		add_command_phase(100, 88, 4, 4);
		add_command_phase(80, 45, 45, 7);
		add_command_phase(90, 10, 80, 7);
		add_command_phase(60, 85, 5, 8);
		add_command_phase(40, 45, 45, 6);
		total_items = pending_commands.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (!(accepted_count == total_items && expected_outcomes.size() == 0));
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Sender: bursts of random length separated by random gaps, fed from pending_commands.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				void'(pending_commands.pop_front());
				accepted_count <= accepted_count + 1;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
				if (burst_left > 0 && pending_commands.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= IN_W'(pending_commands[0]);
					burst_left--;
				end else begin
					s_tvalid <= 1'b0;
					if (burst_left == 0 && gap_left > 0) begin
						gap_left--;
					end
				end
			end
		end
	end

	// Receiver: a stall pattern redrawn at random from four modes, plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 40 == 0) begin
				rx_mode = $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && results_seen >= LONG_HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= (rx_cycle % 3 != 0);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Monitor: checks result transfers first, then predicts for an accepted command, so
	// a prediction made at this edge can never meet a result from the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_outcomes.size() == 0) begin
					$error("result transfer with no expectation waiting: item_value %0d",
						$signed(m_tdata[VAL_W-1:0]));
					error_count++;
				end else begin
					want = expected_outcomes.pop_front();
					if (m_tdata[VAL_W-1:0] !== want.value) begin
						$error("item_value: expected %0d, got %0d", $signed(want.value),
							$signed(m_tdata[VAL_W-1:0]));
						error_count++;
					end
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						error_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						error_count++;
					end
					if (m_tdata[VAL_W +: CNT_W] !== want.count) begin
						$error("count: expected %0d, got %0d", want.count,
							m_tdata[VAL_W +: CNT_W]);
						error_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_deque_command(s_tdata[CMD_W-1:0], s_tdata[CMD_W +: VAL_W]);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

// ===== double_ended_queue_core.f =====
sv/deq_pkg.sv
sv/double_ended_queue_core.sv
verif/double_ended_queue_core_test.sv
